/* src/esq_pkg.sv */
// Shared types and constants for the elevator stop queue.
`default_nettype none
package esq_pkg;

  localparam int MAX_STOPS  = 16;
  localparam int FLOOR_BITS = 8;
  localparam int CNT_W      = $clog2(MAX_STOPS + 1);
  localparam int HEAD_W     = 8;
  localparam int COUNT_W    = 5;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_HEAD   = 2'd1;
  localparam logic [1:0] OP_ERASE  = 2'd2;
  localparam logic [1:0] OP_PEEK   = 2'd3;

  localparam logic [1:0] ST_DONE      = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [1:0] ST_ALREADY   = 2'd3;

  typedef enum logic [1:0] {
    MODE_NONE,
    MODE_ROUTE,
    MODE_HEAD,
    MODE_ERASE
  } cell_mode_e;

  typedef struct packed {
    cell_mode_e            mode;
    logic [FLOOR_BITS-1:0] fl;
  } cell_cmd_t;

  // seen: an insert slot lies at or left of this cell; hit: match at or left of it
  typedef struct packed {
    logic seen;
    logic hit;
  } cell_chain_t;

endpackage
`default_nettype wire

/* src/esq_cell.sv */
// One slot of the stop list: compares, finds its place and shifts with its neighbors.
`default_nettype none
module esq_cell
  import esq_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire cell_cmd_t             cmd_i,
  input  wire logic                  head_cell_i,
  input  wire logic                  valid_i,
  input  wire logic                  left_valid_i,
  input  wire logic [FLOOR_BITS-1:0] left_floor_i,
  input  wire logic [FLOOR_BITS-1:0] right_floor_i,
  input  wire cell_chain_t           chain_i,
  output cell_chain_t                chain_o,
  output logic [FLOOR_BITS-1:0]      floor_o,
  output logic [FLOOR_BITS-1:0]      floor_d_o
);

  logic [FLOOR_BITS-1:0] floor_q, floor_d;
  logic                  is_stop, between, route, append, slot;

  assign is_stop = valid_i && (floor_q == cmd_i.fl);

  assign between = ((left_floor_i > cmd_i.fl) && (floor_q <= cmd_i.fl)) ||
                   ((left_floor_i < cmd_i.fl) && (floor_q >= cmd_i.fl));
  assign route   = !head_cell_i && left_valid_i && valid_i && between;
  assign append  = !valid_i && (left_valid_i || head_cell_i);
  assign slot    = route || append;

  assign chain_o.seen = chain_i.seen || slot;
  assign chain_o.hit  = chain_i.hit || is_stop;

  always_comb begin
    floor_d = floor_q;
    case (cmd_i.mode)
      MODE_ROUTE: begin
        if (chain_i.seen) begin
          floor_d = left_floor_i;
        end else if (slot) begin
          floor_d = cmd_i.fl;
        end
      end
      MODE_HEAD: begin
        if (head_cell_i) begin
          floor_d = cmd_i.fl;
        end else if (!chain_i.hit) begin
          floor_d = left_floor_i;
        end
      end
      MODE_ERASE: begin
        if (chain_i.hit || is_stop) begin
          floor_d = right_floor_i;
        end
      end
      default: floor_d = floor_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    floor_q <= floor_d;
  end

  assign floor_o   = floor_q;
  assign floor_d_o = floor_d;

endmodule
`default_nettype wire

/* src/elevator_stop_queue.sv */
// The result of an accepted request appears on the output register in the next cycle.
// Throughput: one request per cycle while results are taken; all slots of the
// cell row compare and shift together in that cycle.
// A new request is accepted whenever the output register is empty or being read.
// Reset clears the stop count and the output valid; slot contents are not reset.
`default_nettype none
module elevator_stop_queue
  import esq_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] floor
  input  wire logic [1:0]  s_axis_tuser,   // [1:0] op
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [15:0]      m_axis_tdata,   // [7:0] head_floor, [8] list_empty,
                                           // [13:9] stop_count, [15:14] zero
  output logic [1:0]       m_axis_tuser    // [1:0] status
);

  logic [CNT_W-1:0]      count_q, count_d;
  logic                  out_valid_q;
  logic [15:0]           out_data_q, out_data_d;
  logic [1:0]            out_status_q, status_d;
  logic                  accept, present, full;
  cell_cmd_t             cmd;
  logic [MAX_STOPS-1:0]  valid;
  logic [FLOOR_BITS-1:0] floor [MAX_STOPS];
  logic [FLOOR_BITS-1:0] floor_d [MAX_STOPS];
  cell_chain_t           chain [MAX_STOPS+1];
  logic [HEAD_W-1:0]     head_d;
  logic [COUNT_W-1:0]    count_out;

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  assign chain[0].seen = 1'b0;
  assign chain[0].hit  = 1'b0;
  assign present       = chain[MAX_STOPS].hit;
  assign full          = (count_q == CNT_W'(MAX_STOPS));

  for (genvar i = 0; i < MAX_STOPS; i++) begin : g_cell
    assign valid[i] = (CNT_W'(i) < count_q);
    esq_cell u_cell (
      .clk_i        (clk_i),
      .cmd_i        (cmd),
      .head_cell_i  (i == 0),
      .valid_i      (valid[i]),
      .left_valid_i ((i == 0) ? 1'b0 : valid[(i == 0) ? 0 : i-1]),
      .left_floor_i ((i == 0) ? '0 : floor[(i == 0) ? 0 : i-1]),
      .right_floor_i(floor[(i == MAX_STOPS-1) ? i : i+1]),
      .chain_i      (chain[i]),
      .chain_o      (chain[i+1]),
      .floor_o      (floor[i]),
      .floor_d_o    (floor_d[i])
    );
  end

  always_comb begin
    cmd.fl   = s_axis_tdata[FLOOR_BITS-1:0];
    cmd.mode = MODE_NONE;
    status_d = ST_DONE;
    count_d  = count_q;
    unique case (s_axis_tuser)
      OP_INSERT: begin
        if (present) begin
          status_d = ST_ALREADY;
        end else if (full) begin
          status_d = ST_FULL;
        end else begin
          cmd.mode = MODE_ROUTE;
          count_d  = count_q + CNT_W'(1);
        end
      end
      OP_HEAD: begin
        if (present) begin
          cmd.mode = MODE_HEAD;
        end else if (full) begin
          status_d = ST_FULL;
        end else begin
          cmd.mode = MODE_HEAD;
          count_d  = count_q + CNT_W'(1);
        end
      end
      OP_ERASE: begin
        if (present) begin
          cmd.mode = MODE_ERASE;
          count_d  = count_q - CNT_W'(1);
        end else begin
          status_d = ST_NOT_FOUND;
        end
      end
      OP_PEEK: begin
        cmd.mode = MODE_NONE;
      end
      default: cmd.mode = MODE_NONE;
    endcase
    if (!accept) begin
      cmd.mode = MODE_NONE;
      count_d  = count_q;
    end
  end

  assign head_d    = (count_d != '0) ? HEAD_W'(floor_d[0]) : '0;
  assign count_out = COUNT_W'(count_d);
  assign out_data_d = {2'b00, count_out, (count_d == '0), head_d};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_data_q   <= out_data_d;
      out_status_q <= status_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_status_q;

endmodule
`default_nettype wire
